>>> design/kes_pkg.sv
// kes_pkg: shared types and codes for the key event scanner
// used by kes_lane, kes_merge and key_event_scanner_fifo_top; no dependencies

package kes_pkg;

   localparam logic [7:0] PRESS_TICKS_RESET = 8'd2;
   localparam logic [7:0] LONG_TICKS_RESET  = 8'd40;

   // event kinds
   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_LONG    = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;

   // queue fill codes
   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_SOME  = 2'd1;
   localparam logic [1:0] FILL_FULL  = 2'd2;

   // request kinds on req_tuser
   localparam logic REQ_SCAN = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // register indexes
   localparam logic CSR_PRESS_TICKS = 1'b0;
   localparam logic CSR_LONG_TICKS  = 1'b1;

   localparam int INPUT_KEYS = 4;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
   } event_type;

   typedef struct packed {
      logic       ev_valid;
      logic [1:0] ev_key;
      logic [1:0] ev_kind;
      logic [1:0] status;
      logic [2:0] dropped;
   } rsp_type;

endpackage

>>> design/kes_lane.sv
// kes_lane: hold counter and event decision for one key
// depends on kes_pkg for event_type and the event kind codes

module kes_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                tick,
   input  logic                down,
   input  logic [7:0]          press_ticks,
   input  logic [7:0]          long_ticks,
   output kes_pkg::event_type  ev
);

   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] count_inc;

   always_comb begin
      count_inc = count_ff + 8'd1;
      count_in  = count_ff;
      ev        = '0;
      if (down) begin
         count_in = count_inc;
         if (count_inc < press_ticks) begin
            // still debouncing
         end else if (count_inc == press_ticks) begin
            ev.hit  = 1'b1;
            ev.kind = kes_pkg::KIND_PRESS;
         end else if (count_inc >= long_ticks) begin
            ev.hit   = 1'b1;
            ev.kind  = kes_pkg::KIND_LONG;
            count_in = '0;
         end
      end else if (count_ff >= press_ticks) begin
         ev.hit   = 1'b1;
         ev.kind  = kes_pkg::KIND_RELEASE;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (tick) begin
         count_ff <= count_in;
      end
   end

endmodule

>>> design/kes_merge.sv
// kes_merge: walks the lane events in key order into the event ring, serves reads
// and holds the result register; depends on kes_pkg

module kes_merge #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUM_KEYS    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                is_read,
   input  kes_pkg::event_type [NUM_KEYS-1:0]   lane_ev,
   output logic                                ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kes_pkg::rsp_type                    rsp
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ, ST_RDOUT} state_type;

   state_type                     state_ff, state_in;
   logic [NUM_KEYS-1:0]           pend_ff, pend_in;
   logic [NUM_KEYS-1:0][1:0]      kinds_ff, kinds_in;
   logic [2:0]                    drop_ff, drop_in;
   logic [PTR_W-1:0]              wptr_ff, wptr_in;
   logic [PTR_W-1:0]              rptr_ff, rptr_in;
   logic [1:0]                    fill_ff, fill_in;
   logic                          rd_hit_ff, rd_hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   kes_pkg::rsp_type              rsp_ff, rsp_in;
   logic [3:0]                    rd_data_ff;
   logic [3:0]                    mem [QUEUE_DEPTH];
   logic                          mem_we, mem_re;
   logic [3:0]                    mem_wdata;
   logic [1:0]                    pick_key, pick_kind;
   logic                          out_free, finish;
   logic [NUM_KEYS-1:0]           hits;
   logic [NUM_KEYS-1:0][1:0]      kinds;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         hits[i]  = lane_ev[i].hit;
         kinds[i] = lane_ev[i].kind;
      end
   end

   // lowest pending key goes first
   always_comb begin
      pick_key  = '0;
      pick_kind = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pick_key  = 2'(i);
            pick_kind = kinds_ff[i];
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_wdata = {pick_kind, pick_key};

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      kinds_in     = kinds_ff;
      drop_in      = drop_ff;
      wptr_in      = wptr_ff;
      rptr_in      = rptr_ff;
      fill_in      = fill_ff;
      rd_hit_in    = rd_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      finish       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            finish = 1'b1;
         end
         ST_SCAN: begin
            if (pend_ff != '0) begin
               if (fill_ff != kes_pkg::FILL_FULL) begin
                  mem_we  = 1'b1;
                  wptr_in = ptr_next(wptr_ff);
                  fill_in = (wptr_in == rptr_ff) ? kes_pkg::FILL_FULL : kes_pkg::FILL_SOME;
               end else if (drop_ff != 3'd7) begin
                  drop_in = drop_ff + 3'd1;
               end
               pend_in = pend_ff & (pend_ff - 1'b1);
            end
            if (pend_in == '0 && out_free) begin
               finish         = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.status  = fill_in;
               rsp_in.dropped = drop_in;
               state_in       = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_hit_in = 1'b0;
            if (fill_ff != kes_pkg::FILL_EMPTY) begin
               mem_re    = 1'b1;
               rd_hit_in = 1'b1;
               rptr_in   = ptr_next(rptr_ff);
               fill_in   = (rptr_in == wptr_ff) ? kes_pkg::FILL_EMPTY : kes_pkg::FILL_SOME;
            end
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            if (out_free) begin
               finish          = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_in.ev_valid = rd_hit_ff;
               rsp_in.ev_key   = rd_hit_ff ? rd_data_ff[1:0] : 2'd0;
               rsp_in.ev_kind  = rd_hit_ff ? rd_data_ff[3:2] : 2'd0;
               rsp_in.status   = fill_ff;
               rsp_in.dropped  = '0;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (accept) begin
         state_in = is_read ? ST_READ : ST_SCAN;
         pend_in  = is_read ? '0 : hits;
         kinds_in = kinds;
         drop_in  = '0;
      end
   end

   assign ready     = finish;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= '0;
         drop_ff      <= '0;
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         fill_ff      <= kes_pkg::FILL_EMPTY;
         rd_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         drop_ff      <= drop_in;
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         fill_ff      <= fill_in;
         rd_hit_ff    <= rd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kinds_ff <= kinds_in;
      rsp_ff   <= rsp_in;
   end

   // event ring: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wptr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rptr_ff];
      end
   end

   a_full_ptrs : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == kes_pkg::FILL_FULL) |-> (wptr_ff == rptr_ff))
      else $error("full ring with pointers apart");

   a_empty_ptrs : assert property (@(posedge clock) disable iff (reset)
      (fill_ff == kes_pkg::FILL_EMPTY) |-> (wptr_ff == rptr_ff))
      else $error("empty ring with pointers apart");

   a_no_write_full : assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (fill_ff != kes_pkg::FILL_FULL))
      else $error("write into full ring");

   a_read_then_out : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_RDOUT))
      else $error("read did not move to output");

   a_pop_no_drop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.ev_valid) |-> (rsp_ff.dropped == 3'd0))
      else $error("popped event reports drops");

endmodule

>>> design/key_event_scanner_fifo_top.sv
// key_event_scanner_fifo_top: debounced key scanner with an event ring
// depends on kes_pkg, kes_lane and kes_merge
//
// A scan transfer (req_tuser low) updates all NUM_KEYS hold counters at once,
// one lane per key, and its events then enter the ring in key order at one
// per cycle through the ring's single write port; the next request can be
// taken in the same cycle as the last event is handled. A read transfer
// (req_tuser high) does the registered ring read in a read state and then
// answers in an output state. A response still waiting in the output register
// stalls the next response, and so holds off the request after it. Every
// request gives exactly one response; event fields are zero unless rsp_tuser
// is high. The ring holds QUEUE_DEPTH events, events arriving while it is full
// are counted in the response and lost.

module key_event_scanner_fifo_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NUM_KEYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // keys_down[3:0], zero fill
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // event_key[1:0], event_kind[3:2], queue_status[5:4],
                                    // dropped_events[8:6], zero fill
   output logic        rsp_tuser,   // event_valid
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]                         press_ff, long_ff;
   logic                               accept, scan_tick;
   kes_pkg::event_type [NUM_KEYS-1:0]  lane_ev;
   kes_pkg::rsp_type                   rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff <= kes_pkg::PRESS_TICKS_RESET;
         long_ff  <= kes_pkg::LONG_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kes_pkg::CSR_PRESS_TICKS: press_ff <= csr_wdata;
            kes_pkg::CSR_LONG_TICKS:  long_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept    = req_tvalid && req_tready;
   assign scan_tick = accept && (req_tuser == kes_pkg::REQ_SCAN);

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      logic down;
      // keys past the input field always read released
      if (k < kes_pkg::INPUT_KEYS) begin : g_pin
         assign down = req_tdata[k];
      end else begin : g_none
         assign down = 1'b0;
      end
      kes_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .tick        (scan_tick),
         .down        (down),
         .press_ticks (press_ff),
         .long_ticks  (long_ff),
         .ev          (lane_ev[k])
      );
   end

   kes_merge #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NUM_KEYS    (NUM_KEYS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .is_read   (req_tuser == kes_pkg::REQ_READ),
      .lane_ev   (lane_ev),
      .ready     (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.ev_valid;
   assign rsp_tdata = {7'd0, rsp.dropped, rsp.status, rsp.ev_kind, rsp.ev_key};

endmodule

>>> verif/key_event_scanner_fifo_top_tb.sv
`timescale 1ns / 1ps
// key_event_scanner_fifo_top_tb: stream-level test of the key event scanner and its event ring
// depends on kes_pkg and key_event_scanner_fifo_top; scoreboards every response
// against a local model of the hold counters and the ring, or a directed row's expected response

module key_event_scanner_fifo_top_tb;

   localparam int RING_DEPTH = 16;

   typedef struct packed {
      logic             req;
      logic [3:0]       keys;
      logic             typed;
      kes_pkg::rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = kes_pkg::REQ_SCAN;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_index = kes_pkg::CSR_PRESS_TICKS;
   logic [7:0]  csr_wdata = 8'h00;

   // local copy of the scanner state
   logic [7:0] press_thr;
   logic [7:0] long_thr;
   logic [7:0] hold_cnt [kes_pkg::INPUT_KEYS];
   logic [3:0] ring [RING_DEPTH];
   logic [3:0] wr_ptr;
   logic [3:0] rd_ptr;
   logic [1:0] fill;

   kes_pkg::rsp_type awaited_rsps [$];

   // key level generator for well-formed hold sequences
   logic key_level [kes_pkg::INPUT_KEYS];
   int   key_run [kes_pkg::INPUT_KEYS];

   int burst_left = 0;
   int rsp_hold_req = 0;
   int mismatches = 0;
   int n_scans = 0, n_reads = 0, n_popped = 0, n_long = 0, n_dropped = 0;
   int n_full = 0, n_settings = 0;

   key_event_scanner_fifo_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic kes_pkg::rsp_type predict_key_item(input logic req,
                                                         input logic [3:0] keys);
      kes_pkg::rsp_type r;
      logic [7:0]       c;
      logic             has_ev;
      logic [1:0]       kind;
      int               k;
      r = '0;
      if (req == kes_pkg::REQ_SCAN) begin
         for (k = 0; k < kes_pkg::INPUT_KEYS; k++) begin
            has_ev = 1'b0;
            kind = kes_pkg::KIND_PRESS;
            if (keys[k]) begin
               c = hold_cnt[k] + 8'd1;
               hold_cnt[k] = c;
               // press test first, so a press threshold at or above the long one
               // gives the press now and the long hold on the next tick, unless the count wraps
               if (c < press_thr) begin
               end else if (c == press_thr) begin
                  has_ev = 1'b1;
               end else if (c >= long_thr) begin
                  has_ev = 1'b1;
                  kind = kes_pkg::KIND_LONG;
                  hold_cnt[k] = 8'd0;
               end
            end else if (hold_cnt[k] >= press_thr) begin
               has_ev = 1'b1;
               kind = kes_pkg::KIND_RELEASE;
               hold_cnt[k] = 8'd0;
            end
            if (has_ev) begin
               if (fill == kes_pkg::FILL_FULL) begin
                  if (r.dropped < 3'd7)
                     r.dropped = r.dropped + 3'd1;
               end else begin
                  ring[wr_ptr] = {kind, 2'(k)};
                  wr_ptr = wr_ptr + 4'd1;
                  fill = (wr_ptr == rd_ptr) ? kes_pkg::FILL_FULL : kes_pkg::FILL_SOME;
               end
            end
         end
      end else if (fill != kes_pkg::FILL_EMPTY) begin
         r.ev_valid = 1'b1;
         r.ev_key = ring[rd_ptr][1:0];
         r.ev_kind = ring[rd_ptr][3:2];
         rd_ptr = rd_ptr + 4'd1;
         fill = (rd_ptr == wr_ptr) ? kes_pkg::FILL_EMPTY : kes_pkg::FILL_SOME;
      end
      r.status = fill;
      return r;
   endfunction

   task automatic note_mismatch(input string field, input int exp_v, input int got_v);
      if (mismatches < 10)
         $display("mismatch on %s: expected %0d, got %0d", field, exp_v, got_v);
      mismatches++;
   endtask

   // sender: bursts of transfers with random gaps in between
   task automatic offer(input logic req, input logic [3:0] keys, input logic typed,
                        input kes_pkg::rsp_type want);
      int               gap;
      kes_pkg::rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= req;
      req_tdata <= {4'h0, keys};
      do @(posedge clock); while (!req_tready);
      predicted = predict_key_item(req, keys);
      awaited_rsps.push_back(typed ? want : predicted);
      if (req == kes_pkg::REQ_SCAN) n_scans++;
      else n_reads++;
      if (predicted.ev_valid) n_popped++;
      if (predicted.ev_valid && predicted.ev_kind == kes_pkg::KIND_LONG) n_long++;
      if (predicted.status == kes_pkg::FILL_FULL) n_full++;
      n_dropped += int'(predicted.dropped);
   endtask

   // stop offering and wait for every outstanding response
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (awaited_rsps.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic load_thresholds(input logic [7:0] press_v, input logic [7:0] long_v);
      csr_we <= 1'b1;
      csr_index <= kes_pkg::CSR_PRESS_TICKS;
      csr_wdata <= press_v;
      @(posedge clock);
      csr_index <= kes_pkg::CSR_LONG_TICKS;
      csr_wdata <= long_v;
      @(posedge clock);
      csr_we <= 1'b0;
      press_thr = press_v;
      long_thr = long_v;
      n_settings++;
   endtask

   task automatic run_phase(input int items, input int run_lo, input int run_hi,
                            input int drain_pct);
      int         i, k, mode_left, read_pct;
      logic       drain;
      logic [3:0] keys;
      mode_left = 0;
      drain = 1'b0;
      for (k = 0; k < kes_pkg::INPUT_KEYS; k++) begin
         key_level[k] = 1'b1;
         key_run[k] = $urandom_range(run_lo, run_hi);
      end
      for (i = 0; i < items; i++) begin
         // choose at random between filling the ring and draining it
         if (mode_left == 0) begin
            drain = 1'($urandom_range(0, 1));
            mode_left = $urandom_range(10, 50);
         end
         mode_left--;
         read_pct = drain ? drain_pct : 10;
         if ($urandom_range(0, 99) < read_pct) begin
            offer(kes_pkg::REQ_READ, 4'($urandom_range(0, 15)), 1'b0, '0);
         end else if ($urandom_range(0, 9) == 0) begin
            // noise: keys chatter with no run structure
            offer(kes_pkg::REQ_SCAN, 4'($urandom_range(0, 15)), 1'b0, '0);
         end else begin
            for (k = 0; k < kes_pkg::INPUT_KEYS; k++) begin
               if (key_run[k] == 0) begin
                  key_level[k] = ~key_level[k];
                  key_run[k] = $urandom_range(run_lo, run_hi);
               end
               key_run[k]--;
               keys[k] = key_level[k];
            end
            offer(kes_pkg::REQ_SCAN, keys, 1'b0, '0);
         end
      end
   endtask

   // receiver: its own stall pattern, plus a long hold-off on request
   initial begin : receiver
      int mode, mode_left, stall_left, hold_left;
      mode = 0;
      mode_left = 0;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                     if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(4, 24);
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : response_check
      kes_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ev_valid = rsp_tuser;
         got.ev_key = rsp_tdata[1:0];
         got.ev_kind = rsp_tdata[3:2];
         got.status = rsp_tdata[5:4];
         got.dropped = rsp_tdata[8:6];
         if (awaited_rsps.size() == 0) begin
            if (mismatches < 10)
               $display("response transfer with nothing awaited: tdata %h tuser %b",
                        rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = awaited_rsps.pop_front();
            if (got.ev_valid !== want.ev_valid)
               note_mismatch("event_valid", int'(want.ev_valid), int'(got.ev_valid));
            if (got.ev_key !== want.ev_key)
               note_mismatch("event_key", int'(want.ev_key), int'(got.ev_key));
            if (got.ev_kind !== want.ev_kind)
               note_mismatch("event_kind", int'(want.ev_kind), int'(got.ev_kind));
            if (got.status !== want.status)
               note_mismatch("queue_status", int'(want.status), int'(got.status));
            if (got.dropped !== want.dropped)
               note_mismatch("dropped_events", int'(want.dropped), int'(got.dropped));
         end
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows [24];
      int          i, k;
      // after reset, press 2 and long 40
      dir_rows[0]  = {kes_pkg::REQ_READ, 4'h0, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_EMPTY, 3'd0};
      dir_rows[1]  = {kes_pkg::REQ_SCAN, 4'h0, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_EMPTY, 3'd0};
      dir_rows[2]  = {kes_pkg::REQ_SCAN, 4'hf, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_EMPTY, 3'd0};
      dir_rows[3]  = {kes_pkg::REQ_SCAN, 4'hf, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_SOME, 3'd0};
      dir_rows[4]  = {kes_pkg::REQ_READ, 4'h0, 1'b1, 1'b1, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_SOME, 3'd0};
      dir_rows[5]  = {kes_pkg::REQ_READ, 4'h0, 1'b1, 1'b1, 2'd1, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_SOME, 3'd0};
      dir_rows[6]  = {kes_pkg::REQ_READ, 4'h0, 1'b1, 1'b1, 2'd2, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_SOME, 3'd0};
      dir_rows[7]  = {kes_pkg::REQ_READ, 4'h0, 1'b1, 1'b1, 2'd3, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_EMPTY, 3'd0};
      // read from an empty ring, key levels ignored
      dir_rows[8]  = {kes_pkg::REQ_READ, 4'hf, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_EMPTY, 3'd0};
      dir_rows[9]  = {kes_pkg::REQ_SCAN, 4'h0, 1'b1, 1'b0, 2'd0, kes_pkg::KIND_PRESS,
                      kes_pkg::FILL_SOME, 3'd0};
      dir_rows[10] = {kes_pkg::REQ_SCAN, 4'h0, 1'b0, 10'd0};
      dir_rows[11] = {kes_pkg::REQ_READ, 4'h0, 1'b0, 10'd0};
      dir_rows[12] = {kes_pkg::REQ_SCAN, 4'h5, 1'b0, 10'd0};
      dir_rows[13] = {kes_pkg::REQ_SCAN, 4'h5, 1'b0, 10'd0};
      dir_rows[14] = {kes_pkg::REQ_SCAN, 4'ha, 1'b0, 10'd0};
      dir_rows[15] = {kes_pkg::REQ_SCAN, 4'ha, 1'b0, 10'd0};
      dir_rows[16] = {kes_pkg::REQ_SCAN, 4'h0, 1'b0, 10'd0};
      dir_rows[17] = {kes_pkg::REQ_SCAN, 4'hf, 1'b0, 10'd0};
      dir_rows[18] = {kes_pkg::REQ_SCAN, 4'hf, 1'b0, 10'd0};
      // ring fills up here and later events are dropped
      dir_rows[19] = {kes_pkg::REQ_SCAN, 4'h0, 1'b0, 10'd0};
      dir_rows[20] = {kes_pkg::REQ_SCAN, 4'hf, 1'b0, 10'd0};
      dir_rows[21] = {kes_pkg::REQ_SCAN, 4'hf, 1'b0, 10'd0};
      dir_rows[22] = {kes_pkg::REQ_READ, 4'h0, 1'b0, 10'd0};
      dir_rows[23] = {kes_pkg::REQ_SCAN, 4'h8, 1'b0, 10'd0};

      press_thr = kes_pkg::PRESS_TICKS_RESET;
      long_thr = kes_pkg::LONG_TICKS_RESET;
      for (k = 0; k < kes_pkg::INPUT_KEYS; k++)
         hold_cnt[k] = 8'd0;
      for (k = 0; k < RING_DEPTH; k++)
         ring[k] = 4'h0;
      wr_ptr = 4'd0;
      rd_ptr = 4'd0;
      fill = kes_pkg::FILL_EMPTY;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 24; i++)
         offer(dir_rows[i].req, dir_rows[i].keys, dir_rows[i].typed, dir_rows[i].want);
      run_phase(175, 1, 60, 70);

      settle();
      load_thresholds(8'd1, 8'd2);
      // long hold-off on the response side while requests keep coming
      rsp_hold_req = 400;
      run_phase(150, 1, 6, 70);

      settle();
      load_thresholds(8'd1, 8'd255);
      run_phase(125, 200, 400, 30);
      settle();
      run_phase(125, 200, 400, 30);

      // press at the top of the counter range, so long holds wrap the count
      settle();
      load_thresholds(8'd255, 8'd2);
      run_phase(450, 260, 400, 30);

      settle();
      load_thresholds(8'd5, 8'd3);
      run_phase(150, 1, 12, 70);

      settle();
      load_thresholds(8'd3, 8'd8);
      run_phase(150, 1, 20, 70);

      repeat (3) begin
         settle();
         load_thresholds(8'($urandom_range(1, 16)), 8'($urandom_range(2, 24)));
         run_phase(100, 1, 30, 70);
      end

      settle();
      repeat (20) @(posedge clock);
      if (awaited_rsps.size() != 0) begin
         $display("%0d responses never arrived", awaited_rsps.size());
         mismatches += awaited_rsps.size();
      end
      $display("ran %0d scan and %0d read transfers over %0d threshold settings",
               n_scans, n_reads, n_settings);
      $display("popped %0d events (%0d long holds), ring full %0d times, %0d events dropped",
               n_popped, n_long, n_full, n_dropped);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("run timed out");
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
design/kes_pkg.sv
design/kes_lane.sv
design/kes_merge.sv
design/key_event_scanner_fifo_top.sv
verif/key_event_scanner_fifo_top_tb.sv
